>>> hdl/ucjk_pkg.sv
`default_nettype none

package ucjk_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned PointW   = 21;
    localparam int unsigned PartialW = 15;
    localparam int unsigned PendingW = 2;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [PendingW-1:0] bytes_pending;
        logic [PartialW-1:0] partial_point;
        logic                cjk_flag;
    } ucjk_state_t;

    // One result item.
    typedef struct packed {
        logic              point_done;
        logic [PointW-1:0] code_point;
        logic              point_is_cjk;
        logic              seen_cjk;
        logic              end_of_name;
    } ucjk_result_t;

    function automatic logic ucjk_is_cjk(input logic [PointW-1:0] cp);
        return cp inside {[21'h01100:21'h011FF], [21'h03040:21'h030FF],
                          [21'h03400:21'h04DBF], [21'h04E00:21'h09FFF],
                          [21'h0AC00:21'h0D7AF], [21'h0F900:21'h0FAFF],
                          [21'h20000:21'h2FA1F]};
    endfunction

endpackage

`default_nettype wire

>>> hdl/ucjk_in_if.sv
`default_nettype none

interface ucjk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

`default_nettype wire

>>> hdl/ucjk_out_if.sv
`default_nettype none

interface ucjk_out_if;
    logic        valid;
    logic        ready;
    logic        point_done;
    logic [20:0] code_point;
    logic        point_is_cjk;
    logic        seen_cjk;
    logic        end_of_name;

    modport source (output valid, output point_done, output code_point,
                    output point_is_cjk, output seen_cjk, output end_of_name,
                    input ready);
    modport sink   (input valid, input point_done, input code_point,
                    input point_is_cjk, input seen_cjk, input end_of_name,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/ucjk_decode.sv
`default_nettype none

module ucjk_decode (
    input  wire logic [7:0]           byte_in,
    input  wire logic                 last_byte,
    input  wire ucjk_pkg::ucjk_state_t  state,
    output      ucjk_pkg::ucjk_state_t  state_next,
    output      ucjk_pkg::ucjk_result_t result
);
    import ucjk_pkg::*;

    logic              is_cont;
    logic              done;
    logic [PointW-1:0] cp;
    logic              cp_cjk;
    logic              flag;

    assign is_cont = (state.bytes_pending != '0) && (byte_in[7:6] == 2'b10);

    always_comb
    begin
        state_next.bytes_pending = '0;
        state_next.partial_point = '0;
        done                     = 1'b0;
        cp                       = '0;
        if (is_cont)
        begin
            if (state.bytes_pending == 2'd1)
            begin
                cp   = {state.partial_point, byte_in[5:0]};
                done = 1'b1;
            end
            else
            begin
                state_next.partial_point = {state.partial_point[PartialW-7:0], byte_in[5:0]};
                state_next.bytes_pending = state.bytes_pending - 2'd1;
            end
        end
        else
        begin
            // Any open sequence is dropped and this byte starts fresh.
            if (byte_in[7] == 1'b0)
            begin
                cp   = {13'd0, byte_in};
                done = 1'b1;
            end
            else if (byte_in[7:5] == 3'b110)
            begin
                state_next.partial_point = {10'd0, byte_in[4:0]};
                state_next.bytes_pending = 2'd1;
            end
            else if (byte_in[7:4] == 4'b1110)
            begin
                state_next.partial_point = {11'd0, byte_in[3:0]};
                state_next.bytes_pending = 2'd2;
            end
            else if (byte_in[7:3] == 5'b11110)
            begin
                state_next.partial_point = {12'd0, byte_in[2:0]};
                state_next.bytes_pending = 2'd3;
            end
        end

        cp_cjk = done && ucjk_is_cjk(cp);
        flag   = state.cjk_flag | cp_cjk;

        result.point_done   = done;
        result.code_point   = cp;
        result.point_is_cjk = cp_cjk;
        result.seen_cjk     = flag;
        result.end_of_name  = last_byte;

        state_next.cjk_flag = flag;
        if (last_byte)
        begin
            state_next = '0;
        end
    end

endmodule

`default_nettype wire

>>> hdl/utf8_cjk_letter_detector.sv
`default_nettype none

// Decodes a name given one byte per transfer as UTF-8 (one to four bytes per
// code point) and gives exactly one result per byte: whether the byte
// completed a code point, the code point, whether it is a CJK letter, and a
// sticky flag for any CJK letter so far in the name. A byte with last_byte
// set ends the name and clears all decoder state. The block takes one byte
// every cycle while the output is not stalled; a byte passes an input
// register and then a result register before its result is offered. The
// two registers let a new byte be taken while a result waits.
module utf8_cjk_letter_detector (
    input wire logic   clk,
    input wire logic   rst_n,
    ucjk_in_if.sink    in_ch,
    ucjk_out_if.source out_ch
);
    import ucjk_pkg::*;

    logic               in_valid_reg;
    logic [ByteW-1:0]   byte_reg;
    logic               last_reg;
    logic               res_valid_reg;
    ucjk_result_t       res_reg;
    ucjk_result_t       res_next;
    ucjk_state_t        state_reg;
    ucjk_state_t        state_next;
    logic               advance;
    logic               move;

    assign advance     = !res_valid_reg || out_ch.ready;
    assign move        = in_valid_reg && advance;
    assign in_ch.ready = !in_valid_reg || advance;

    ucjk_decode u_decode (
        .byte_in    (byte_reg),
        .last_byte  (last_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
            end
            if (move)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            byte_reg <= in_ch.byte_in;
            last_reg <= in_ch.last_byte;
        end
        if (move)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid        = res_valid_reg;
    assign out_ch.point_done   = res_reg.point_done;
    assign out_ch.code_point   = res_reg.code_point;
    assign out_ch.point_is_cjk = res_reg.point_is_cjk;
    assign out_ch.seen_cjk     = res_reg.seen_cjk;
    assign out_ch.end_of_name  = res_reg.end_of_name;

endmodule

`default_nettype wire

>>> hdl/ucjk_checker.sv
`default_nettype none

module ucjk_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        point_done,
    input wire logic [20:0] code_point,
    input wire logic        point_is_cjk,
    input wire logic        seen_cjk
);

    // A result that is not a finished code point carries zeros.
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !point_done) |-> (code_point == 21'd0 && !point_is_cjk))
        else $error("result without a code point carries nonzero fields");

    // A CJK letter in this result must be reflected in the sticky flag.
    a_cjk_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && point_is_cjk) |-> seen_cjk)
        else $error("CJK letter reported without the sticky flag");

    // An ASCII code point can never be a CJK letter.
    a_ascii_not_cjk: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && point_done && code_point[20:7] == 14'd0) |-> !point_is_cjk)
        else $error("ASCII code point flagged as CJK");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn before its transfer");

endmodule

bind utf8_cjk_letter_detector ucjk_checker u_ucjk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .point_done   (out_ch.point_done),
    .code_point   (out_ch.code_point),
    .point_is_cjk (out_ch.point_is_cjk),
    .seen_cjk     (out_ch.seen_cjk)
);

`default_nettype wire

>>> verif/testbench.sv
`default_nettype none

module testbench;

    import ucjk_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned RANDOM_BYTES   = 1100;
    localparam int unsigned NUM_PHASES     = 4;
    localparam int unsigned DRAIN_CYCLES   = 10;

    // Letter ranges, lowest to highest.
    localparam logic [20:0] CJK_LO [7] = '{21'h01100, 21'h03040, 21'h03400, 21'h04E00,
                                           21'h0AC00, 21'h0F900, 21'h20000};
    localparam logic [20:0] CJK_HI [7] = '{21'h011FF, 21'h030FF, 21'h04DBF, 21'h09FFF,
                                           21'h0D7AF, 21'h0FAFF, 21'h2FA1F};

    // Bit 8 is the end-of-name mark, bits 7:0 the byte.
    localparam logic [8:0] DIRECTED_BYTES [24] = '{
        9'h000, 9'h17F,                 // single bytes, low and high
        9'h0C0, 9'h080,                 // overlong two-byte form of zero
        9'h0DF, 9'h0BF,                 // largest two-byte value
        9'h0E1, 9'h084, 9'h080,         // first Hangul Jamo letter
        9'h0F0, 9'h0A0, 9'h080, 9'h080, // first supplementary ideograph
        9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, // largest four-byte value
        9'h080,                         // stray continuation
        9'h0F8, 9'h1FF,                 // invalid leads, the second ends the name
        9'h0E3, 9'h041,                 // broken sequence, then a plain letter
        9'h0E3, 9'h181                  // sequence cut short by the end of the name
    };

    class name_decode_board;
        logic [1:0]   pending = '0;
        logic [14:0]  partial = '0;
        logic         cjk_seen = 1'b0;
        ucjk_result_t expected_q[$];
        int           mismatches;
        int           results_checked;
        int           points_done;
        int           cjk_points;
        int           names_ended;

        function bit is_cjk_letter(logic [20:0] cp);
            for (int r = 0; r < 7; r++)
            begin
                if (cp >= CJK_LO[r] && cp <= CJK_HI[r])
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            ucjk_result_t res;
            res = '0;
            if (pending != 2'd0 && b[7:6] == 2'b10)
            begin
                if (pending == 2'd1)
                begin
                    res.point_done = 1'b1;
                    res.code_point = {partial, b[5:0]};
                    pending = 2'd0;
                    partial = '0;
                end
                else
                begin
                    partial = {partial[8:0], b[5:0]};
                    pending = pending - 2'd1;
                end
            end
            else
            begin
                // An open sequence broken by this byte is simply dropped.
                pending = 2'd0;
                partial = '0;
                if (b[7] == 1'b0)
                begin
                    res.point_done = 1'b1;
                    res.code_point = {14'd0, b[6:0]};
                end
                else if (b[7:5] == 3'b110)
                begin
                    partial = {10'd0, b[4:0]};
                    pending = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    partial = {11'd0, b[3:0]};
                    pending = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    partial = {12'd0, b[2:0]};
                    pending = 2'd3;
                end
            end
            if (res.point_done && is_cjk_letter(res.code_point))
            begin
                res.point_is_cjk = 1'b1;
                cjk_seen = 1'b1;
            end
            res.seen_cjk = cjk_seen;
            res.end_of_name = last;
            if (last)
            begin
                pending = 2'd0;
                partial = '0;
                cjk_seen = 1'b0;
            end
            expected_q.push_back(res);
        endfunction

        function void compare_field(string field, logic [20:0] want, logic [20:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, actual %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(ucjk_result_t got);
            ucjk_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with no byte waiting for it: code_point %0h", got.code_point);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            points_done += int'(want.point_done);
            cjk_points += int'(want.point_is_cjk);
            names_ended += int'(want.end_of_name);
            compare_field("point_done", 21'(want.point_done), 21'(got.point_done));
            compare_field("code_point", want.code_point, got.code_point);
            compare_field("point_is_cjk", 21'(want.point_is_cjk), 21'(got.point_is_cjk));
            compare_field("seen_cjk", 21'(want.seen_cjk), 21'(got.seen_cjk));
            compare_field("end_of_name", 21'(want.end_of_name), 21'(got.end_of_name));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   bytes_sent;
    logic [7:0] name_buf[$];

    name_decode_board board = new;

    ucjk_in_if  byte_ch ();
    ucjk_out_if result_ch ();

    utf8_cjk_letter_detector dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (byte_ch),
        .out_ch (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= stall_pct);

    // The byte is noted before the result is checked, so a same-cycle
    // result would still find its expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
                board.note_byte(byte_ch.byte_in, byte_ch.last_byte);
            if (result_ch.valid && result_ch.ready)
                board.check_result('{point_done:   result_ch.point_done,
                                     code_point:   result_ch.code_point,
                                     point_is_cjk: result_ch.point_is_cjk,
                                     seen_cjk:     result_ch.seen_cjk,
                                     end_of_name:  result_ch.end_of_name});
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.byte_in   <= b;
        byte_ch.last_byte <= last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    function automatic void push_point(logic [20:0] cp, int len);
        case (len)
            1: name_buf.push_back({1'b0, cp[6:0]});
            2:
            begin
                name_buf.push_back({3'b110, cp[10:6]});
                name_buf.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                name_buf.push_back({4'b1110, cp[15:12]});
                name_buf.push_back({2'b10, cp[11:6]});
                name_buf.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                name_buf.push_back({5'b11110, cp[20:18]});
                name_buf.push_back({2'b10, cp[17:12]});
                name_buf.push_back({2'b10, cp[11:6]});
                name_buf.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Mostly well-formed code points, with CJK range edges, noise bytes
    // and broken sequences mixed in.
    function automatic void push_random_item();
        int          kind;
        int          r;
        int          len;
        logic [20:0] cp;
        kind = $urandom_range(99);
        if (kind < 30)
            push_point(21'($urandom_range(127)), 1);
        else if (kind < 45)
            push_point(21'($urandom_range(21'h7FF)), 2);
        else if (kind < 60)
            push_point(21'($urandom_range(21'hFFFF)), 3);
        else if (kind < 70)
            push_point(21'($urandom_range(21'h1FFFFF)), 4);
        else if (kind < 85)
        begin
            r = $urandom_range(6);
            case ($urandom_range(4))
                0: cp = CJK_LO[r] - 21'd1;
                1: cp = CJK_LO[r];
                2: cp = CJK_HI[r];
                3: cp = CJK_HI[r] + 21'd1;
                default: cp = CJK_LO[r] + 21'($urandom_range(CJK_HI[r] - CJK_LO[r]));
            endcase
            len = (cp < 21'h10000) ? 3 : 4;
            push_point(cp, len);
        end
        else if (kind < 93)
            name_buf.push_back(8'($urandom_range(255)));
        else
        begin
            len = $urandom_range(2, 4);
            case (len)
                2: name_buf.push_back({3'b110, 5'($urandom)});
                3: name_buf.push_back({4'b1110, 4'($urandom)});
                default: name_buf.push_back({5'b11110, 3'($urandom)});
            endcase
            repeat ($urandom_range(len - 2))
                name_buf.push_back({2'b10, 6'($urandom)});
        end
    endfunction

    task automatic send_random_name();
        name_buf.delete();
        repeat ($urandom_range(1, 10))
            push_random_item();
        for (int i = 0; i < name_buf.size(); i++)
            send_byte(name_buf[i], i == name_buf.size() - 1);
    endtask

    initial
    begin
        int phase_target;
        rst_n             = 1'b0;
        idle_pct          = 0;
        stall_pct         = 0;
        bytes_sent        = 0;
        byte_ch.valid     = 1'b0;
        byte_ch.byte_in   = '0;
        byte_ch.last_byte = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_BYTES[i])
            send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 81;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 81;
                end
                default:
                begin
                    idle_pct  = 8;
                    stall_pct = 8;
                end
            endcase
            phase_target = bytes_sent + RANDOM_BYTES / NUM_PHASES;
            while (bytes_sent < phase_target)
                send_random_name();
        end

        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d bytes in %0d names under four idle and stall patterns",
                 bytes_sent, board.names_ended);
        $display("checked %0d results: %0d code points, %0d of them CJK letters",
                 board.results_checked, board.points_done, board.cjk_points);
        if (board.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

>>> utf8_cjk_letter_detector.f
hdl/ucjk_pkg.sv
hdl/ucjk_in_if.sv
hdl/ucjk_out_if.sv
hdl/ucjk_decode.sv
hdl/utf8_cjk_letter_detector.sv
hdl/ucjk_checker.sv
verif/testbench.sv
